// ----- hdl/pc_map_probe_table_core_macros.svh -----
// Assertion macros shared by the probe table core.
`ifndef PC_MAP_PROBE_TABLE_CORE_MACROS_SVH
`define PC_MAP_PROBE_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PMPT_ASSERT_HOLDS(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pc_map_probe_table_core: check failed");

// next-cycle implication, sampled on clk, off during reset
`define PMPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pc_map_probe_table_core: check failed");

`endif

// ----- hdl/pmpt_pkg.sv -----
// Types and constants of the probe table core.
package pmpt_pkg;

	localparam int KEY_W         = 32;
	localparam int VAL_W         = 32;
	localparam int PROBE_LIMIT_W = 11;
	localparam int HASH_SHIFT    = 2;
	localparam int HASH_BITS     = KEY_W - HASH_SHIFT;
	localparam int HASH_STEPS    = 2;
	localparam int HASH_CNT_W    = $clog2(HASH_STEPS + 1);

	localparam logic [PROBE_LIMIT_W-1:0] PROBE_LIMIT_RST = 11'd102;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [KEY_W-1:0] translated_addr;
		logic [VAL_W-1:0] original_addr_in;
	} pmpt_req_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] original_addr_out;
		logic             insert_failed;
	} pmpt_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_CHECK,
		ST_RDHOME,
		ST_SWAP_SLOT,
		ST_SWAP_HOME,
		ST_DONE
	} pmpt_state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_EMPTY,
		RES_HIT_RD,
		RES_HIT_FOUND,
		RES_FAIL
	} pmpt_res_t;

	typedef struct packed {
		logic      clr_wr;
		logic      load;
		logic      hash_step;
		logic      slot_init;
		logic      rd_home;
		logic      adv;
		logic      wr_ins;
		logic      wr_slot_home;
		logic      wr_home_found;
		logic      keep_found;
		pmpt_res_t res;
		logic      out_load;
	} pmpt_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hash_done;
		logic is_insert;
		logic key_zero;
		logic rk_empty;
		logic rk_match;
		logic at_home;
		logic lap_done;
		logic limit_hit;
		logic out_free;
	} pmpt_sts_t;

endpackage

// ----- hdl/pmpt_ram.sv -----
// Generic simple dual-port RAM with registered read.
module pmpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/pmpt_ctrl.sv -----
// Controller state machine of the probe table core.
module pmpt_ctrl import pmpt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  pmpt_sts_t sts,
	output pmpt_cmd_t cmd
);

	pmpt_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_done) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nx = ST_HASH;
			end
			ST_HASH: begin
				if (sts.hash_done) begin
					if (sts.is_insert && sts.key_zero) state_nx = ST_DONE;
					else state_nx = ST_PROBE;
				end
			end
			ST_PROBE: state_nx = ST_CHECK;
			ST_CHECK: begin
				if (sts.rk_empty) begin
					state_nx = ST_DONE;
				end else if (!sts.is_insert && sts.rk_match) begin
					state_nx = sts.at_home ? ST_DONE : ST_RDHOME;
				end else if (sts.lap_done || (sts.is_insert && sts.limit_hit)) begin
					state_nx = ST_DONE;
				end else begin
					state_nx = ST_PROBE;
				end
			end
			ST_RDHOME:    state_nx = ST_SWAP_SLOT;
			ST_SWAP_SLOT: state_nx = ST_SWAP_HOME;
			ST_SWAP_HOME: state_nx = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res = RES_NONE;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE:  cmd.load = in_valid;
			ST_HASH: begin
				if (sts.hash_done) begin
					if (sts.is_insert && sts.key_zero) cmd.res = RES_FAIL;
					else cmd.slot_init = 1'b1;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			ST_PROBE: ;
			ST_CHECK: begin
				if (sts.rk_empty) begin
					cmd.wr_ins = sts.is_insert;
					cmd.res    = RES_EMPTY;
				end else if (!sts.is_insert && sts.rk_match) begin
					if (sts.at_home) begin
						cmd.res = RES_HIT_RD;
					end else begin
						cmd.keep_found = 1'b1;
						cmd.rd_home    = 1'b1;
					end
				end else begin
					cmd.adv = 1'b1;
					if (sts.is_insert && (sts.limit_hit || sts.lap_done)) begin
						cmd.res = RES_FAIL;
					end else if (sts.lap_done) begin
						cmd.res = RES_EMPTY;
					end
				end
			end
			ST_RDHOME:    cmd.rd_home = 1'b1;
			ST_SWAP_SLOT: cmd.wr_slot_home = 1'b1;
			ST_SWAP_HOME: begin
				cmd.wr_home_found = 1'b1;
				cmd.res           = RES_HIT_FOUND;
			end
			ST_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- hdl/pmpt_dp.sv -----
// Datapath of the probe table core: hash, probe registers, stores, result.
module pmpt_dp import pmpt_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pmpt_req_t                in_req,
	input  logic                     cfg_wr_en,
	input  logic [PROBE_LIMIT_W-1:0] cfg_wr_data,
	input  logic                     out_stall,
	output logic                     out_valid,
	output pmpt_rsp_t                out_rsp,
	input  pmpt_cmd_t                cmd,
	output pmpt_sts_t                sts
);

	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int CW     = (AW + 1 > PROBE_LIMIT_W) ? AW + 1 : PROBE_LIMIT_W;
	localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam int RECIP_SH = HASH_BITS + AW;
	localparam int PROD_W   = (RECIP_SH + AW > 2 * HASH_BITS + 1) ? RECIP_SH + AW
		: 2 * HASH_BITS + 1;
	localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SH;
	localparam logic [HASH_BITS:0] RECIP_M =
		(HASH_BITS + 1)'((RECIP_ONE + 64'(TABLE_DEPTH - 1)) / 64'(TABLE_DEPTH));
	localparam logic [AW:0]   DEPTH_V   = (AW + 1)'(TABLE_DEPTH);
	localparam logic [AW-1:0] SLOT_LAST = AW'(TABLE_DEPTH - 1);
	localparam logic [AW-1:0] DEPTH_LO  = AW'(TABLE_DEPTH);

	logic                     mode_q;
	logic [KEY_W-1:0]         key_q;
	logic [VAL_W-1:0]         val_q;
	logic [AW-1:0]            quo_q;
	logic [HASH_CNT_W-1:0]    cnt_q;
	logic [AW-1:0]            rem_q;
	logic [AW-1:0]            slot_q;
	logic [AW:0]              steps_q;
	logic [VAL_W-1:0]         found_q;
	logic [AW-1:0]            clr_q;
	logic [PROBE_LIMIT_W-1:0] limit_q;
	logic                     res_hit_q;
	logic [VAL_W-1:0]         res_val_q;
	logic                     res_fail_q;
	logic                     out_valid_q;
	pmpt_rsp_t                out_rsp_q;

	logic [HASH_BITS-1:0] hsh;
	logic [PROD_W-1:0]    hsh_prod;
	logic [AW:0]       steps_nx;
	logic [AW-1:0]     slot_nx;
	logic [AW-1:0]     raddr;
	logic              k_we;
	logic [AW-1:0]     k_waddr;
	logic [KEY_W-1:0]  k_wdata;
	logic [KEY_W-1:0]  k_rd;
	logic              v_we;
	logic [AW-1:0]     v_waddr;
	logic [VAL_W-1:0]  v_wdata;
	logic [VAL_W-1:0]  v_rd;

	assign hsh      = key_q[KEY_W-1:HASH_SHIFT];
	assign hsh_prod = PROD_W'(hsh) * PROD_W'(RECIP_M);
	assign steps_nx = steps_q + 1'b1;
	assign slot_nx  = (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
	assign raddr    = cmd.rd_home ? rem_q : slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			limit_q     <= PROBE_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			if (cmd.load) begin
				cnt_q <= IS_POW2 ? '0 : HASH_CNT_W'(HASH_STEPS);
			end else if (cmd.hash_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_req.mode;
			key_q   <= in_req.translated_addr;
			val_q   <= in_req.original_addr_in;
			steps_q <= '0;
			rem_q   <= IS_POW2 ? in_req.translated_addr[HASH_SHIFT +: AW] : '0;
		end else if (cmd.hash_step) begin
			if (cnt_q == HASH_CNT_W'(HASH_STEPS)) begin
				quo_q <= hsh_prod[RECIP_SH +: AW];
			end else begin
				rem_q <= hsh[AW-1:0] - quo_q * DEPTH_LO;
			end
		end
		if (cmd.slot_init) slot_q <= rem_q;
		else if (cmd.adv) slot_q <= slot_nx;
		if (cmd.adv) steps_q <= steps_nx;
		if (cmd.keep_found) found_q <= v_rd;
		unique case (cmd.res)
			RES_EMPTY: begin
				res_hit_q  <= 1'b0;
				res_val_q  <= '0;
				res_fail_q <= 1'b0;
			end
			RES_HIT_RD: begin
				res_hit_q  <= 1'b1;
				res_val_q  <= v_rd;
				res_fail_q <= 1'b0;
			end
			RES_HIT_FOUND: begin
				res_hit_q  <= 1'b1;
				res_val_q  <= found_q;
				res_fail_q <= 1'b0;
			end
			RES_FAIL: begin
				res_hit_q  <= 1'b0;
				res_val_q  <= '0;
				res_fail_q <= 1'b1;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			out_rsp_q.hit               <= res_hit_q;
			out_rsp_q.original_addr_out <= res_val_q;
			out_rsp_q.insert_failed     <= res_fail_q;
		end
	end

	always_comb begin
		k_we    = 1'b1;
		k_waddr = slot_q;
		k_wdata = key_q;
		priority if (cmd.clr_wr) begin
			k_waddr = clr_q;
			k_wdata = '0;
		end else if (cmd.wr_ins) begin
			k_waddr = slot_q;
			k_wdata = key_q;
		end else if (cmd.wr_slot_home) begin
			k_waddr = slot_q;
			k_wdata = k_rd;
		end else if (cmd.wr_home_found) begin
			k_waddr = rem_q;
			k_wdata = key_q;
		end else begin
			k_we = 1'b0;
		end
	end

	always_comb begin
		v_we    = 1'b1;
		v_waddr = slot_q;
		v_wdata = val_q;
		priority if (cmd.wr_ins) begin
			v_waddr = slot_q;
			v_wdata = val_q;
		end else if (cmd.wr_slot_home) begin
			v_waddr = slot_q;
			v_wdata = v_rd;
		end else if (cmd.wr_home_found) begin
			v_waddr = rem_q;
			v_wdata = found_q;
		end else begin
			v_we = 1'b0;
		end
	end

	pmpt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (k_we),
		.waddr (k_waddr),
		.wdata (k_wdata),
		.raddr (raddr),
		.rdata (k_rd)
	);

	pmpt_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (raddr),
		.rdata (v_rd)
	);

	assign sts.clr_done  = (clr_q == SLOT_LAST);
	assign sts.hash_done = (cnt_q == '0);
	assign sts.is_insert = (mode_q == MODE_INSERT);
	assign sts.key_zero  = (key_q == '0);
	assign sts.rk_empty  = (k_rd == '0);
	assign sts.rk_match  = (k_rd == key_q);
	assign sts.at_home   = (steps_q == '0);
	assign sts.lap_done  = (steps_nx == DEPTH_V);
	assign sts.limit_hit = (CW'(steps_nx) >= CW'(limit_q));
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

endmodule

// ----- hdl/pc_map_probe_table_core.sv -----
// Top level of the probe table core: open-addressed map from translated to original address.
// Linear-probing hash table with TABLE_DEPTH entries in two single-port-read RAMs. After reset
// the key store is swept clear slot by slot; no request is taken during that pass.
// One request is handled at a time. Each probe is a RAM read (PROBE) followed by a compare
// (CHECK); a lookup that hits away from home also reads the home slot and swaps that entry to
// the home slot. When TABLE_DEPTH is not a power of two the home slot is reduced by a
// reciprocal multiply and a subtract before probing starts. A finished result sits in the
// output register while the next request is accepted; while a stalled result keeps the
// register full, the following one waits in the done state.
`include "pc_map_probe_table_core_macros.svh"

module pc_map_probe_table_core import pmpt_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  pmpt_req_t                in_req,
	output logic                     out_valid,
	input  logic                     out_stall,
	output pmpt_rsp_t                out_rsp,
	input  logic                     cfg_wr_en,
	input  logic [PROBE_LIMIT_W-1:0] cfg_wr_data
);

	pmpt_cmd_t cmd;
	pmpt_sts_t sts;

	pmpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pmpt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_req      (in_req),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_rsp     (out_rsp),
		.cmd         (cmd),
		.sts         (sts)
	);

	`PMPT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`PMPT_ASSERT_HOLDS(a_hit_not_failed, out_valid, !(out_rsp.hit && out_rsp.insert_failed))
	`PMPT_ASSERT_HOLDS(a_miss_zero_value, out_valid && !out_rsp.hit,
		out_rsp.original_addr_out == '0)

endmodule
